/* design/fpma_pkg.sv */
// ----------------------------------------------------------------------------
// Fit-policy memory allocator package
// Shared constants, request and status codes, and the segment table write
// enable group.
// ----------------------------------------------------------------------------
package fpma_pkg;

    localparam int MEM_UNITS_DEF = 1024;

    localparam int OWN_W = 11;
    localparam int END_W = 17;
    localparam int SIZE_W = 11;
    localparam int ID_W = 10;
    localparam int TIME_W = 16;
    localparam int POS_W = 10;

    localparam logic [OWN_W-1:0] FREE_MARK = 11'h7FF;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_RELEASE = 2'd2;

    typedef struct packed {
        logic owner;
        logic next;
        logic end_time;
    } t_tbl_we;

endpackage

/* design/fpma_seg_table.sv */
// ----------------------------------------------------------------------------
// Fit-policy memory allocator segment table
// Owner, next-link and end-time memories with one write port and one
// registered read port. Entry zero reads as a free segment spanning all
// memory until it is written after reset.
// ----------------------------------------------------------------------------
module fpma_seg_table #(
    parameter int MEM_UNITS = fpma_pkg::MEM_UNITS_DEF,
    parameter int AW = $clog2(MEM_UNITS),
    parameter int PW = AW + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [AW-1:0]                 i_rd_addr,
    input  fpma_pkg::t_tbl_we             i_we,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [fpma_pkg::OWN_W-1:0]    i_wr_owner,
    input  logic [PW-1:0]                 i_wr_next,
    input  logic [fpma_pkg::END_W-1:0]    i_wr_end,
    output logic [fpma_pkg::OWN_W-1:0]    o_rd_owner,
    output logic [PW-1:0]                 o_rd_next,
    output logic [fpma_pkg::END_W-1:0]    o_rd_end
);
    import fpma_pkg::*;

    logic [OWN_W-1:0] r_mem_owner [MEM_UNITS];
    logic [PW-1:0]    r_mem_next  [MEM_UNITS];
    logic [END_W-1:0] r_mem_end   [MEM_UNITS];

    logic [OWN_W-1:0] r_q_owner;
    logic [PW-1:0]    r_q_next;
    logic [END_W-1:0] r_q_end;
    logic             r_rd_zero;
    logic             r_own0_rst;
    logic             r_nxt0_rst;

    always_ff @(posedge i_clk) begin
        if (i_we.owner) begin
            r_mem_owner[i_wr_addr] <= i_wr_owner;
        end
        if (i_we.next) begin
            r_mem_next[i_wr_addr] <= i_wr_next;
        end
        if (i_we.end_time) begin
            r_mem_end[i_wr_addr] <= i_wr_end;
        end
        r_q_owner <= r_mem_owner[i_rd_addr];
        r_q_next  <= r_mem_next[i_rd_addr];
        r_q_end   <= r_mem_end[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own0_rst <= 1'b1;
            r_nxt0_rst <= 1'b1;
            r_rd_zero  <= 1'b0;
        end else begin
            r_rd_zero <= (i_rd_addr == '0);
            if (i_we.owner && i_wr_addr == '0) begin
                r_own0_rst <= 1'b0;
            end
            if (i_we.next && i_wr_addr == '0) begin
                r_nxt0_rst <= 1'b0;
            end
        end
    end

    assign o_rd_owner = (r_rd_zero && r_own0_rst) ? FREE_MARK : r_q_owner;
    assign o_rd_next  = (r_rd_zero && r_nxt0_rst) ? PW'(MEM_UNITS) : r_q_next;
    assign o_rd_end   = r_q_end;

endmodule

/* design/fit_policy_memory_allocator.sv */
// ----------------------------------------------------------------------------
// Fit-policy memory allocator
// Keeps a chain of memory segments and serves allocate and release requests
// with first, best or worst fit placement.
// ----------------------------------------------------------------------------
// Usage: a request enters on i_in_valid when o_in_stall is low. An allocate
// walks the segment chain one segment per cycle, then writes the allocated
// segment and, if a remainder is left, a free segment after it. A release
// walks the chain once to free segments whose end time matches i_now_time,
// then walks it again one segment per cycle to merge neighboring free
// segments. A zero size allocate finishes without a walk. The time taken is
// set by the number of segments on the chain and the single read port of
// the segment table. One request is worked on at a time and o_in_stall
// stays high until it is finished.
// Each request yields one result on o_out_valid, held in an output register
// until i_out_stall is low; while a result waits there, the next request is
// accepted and worked on, and only its own result waits for the register.
// The user must write the placement mode on the configuration channel only
// while idle; the block does not enforce this. Reset sets first fit and
// leaves one free segment spanning all memory; there is no clearing pass.
// ----------------------------------------------------------------------------
module fit_policy_memory_allocator #(
    parameter int MEM_UNITS = fpma_pkg::MEM_UNITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_fit_mode,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_req_type,
    input  logic [fpma_pkg::ID_W-1:0]      i_owner_id,
    input  logic [fpma_pkg::SIZE_W-1:0]    i_req_size,
    input  logic [fpma_pkg::TIME_W-1:0]    i_now_time,
    input  logic [fpma_pkg::TIME_W-1:0]    i_burst_time,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_status,
    output logic [fpma_pkg::POS_W-1:0]     o_position
);
    import fpma_pkg::*;

    localparam int AW = $clog2(MEM_UNITS);
    localparam int PW = AW + 1;
    localparam int LW = (PW > SIZE_W) ? PW : SIZE_W;
    localparam logic [PW-1:0] MEM_P = PW'(MEM_UNITS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIND   = 4'd1;
    localparam logic [3:0] S_ALLOC  = 4'd2;
    localparam logic [3:0] S_SPLIT  = 4'd3;
    localparam logic [3:0] S_REL    = 4'd4;
    localparam logic [3:0] S_MISSUE = 4'd5;
    localparam logic [3:0] S_MSTART = 4'd6;
    localparam logic [3:0] S_MERGE  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    function automatic logic [PW-1:0] f_link(input logic [PW-1:0] pos,
                                             input logic [PW-1:0] nxt);
        if (nxt <= pos || nxt > MEM_P) begin
            f_link = MEM_P;
        end else begin
            f_link = nxt;
        end
    endfunction

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_fit_mode;
    logic [PW-1:0]     r_pos, n_pos;
    logic [PW-1:0]     r_link, n_link;
    logic [PW-1:0]     r_best, n_best;
    logic [PW-1:0]     r_best_len, n_best_len;
    logic              r_have, n_have;
    logic              r_cur_free, n_cur_free;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_status, n_status;
    logic [POS_W-1:0]  r_position, n_position;
    logic [1:0]        r_res_status, n_res_status;
    logic [PW-1:0]     r_res_pos, n_res_pos;
    logic [OWN_W-1:0]  r_owner, n_owner;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [TIME_W-1:0] r_now, n_now;
    logic [END_W-1:0]  r_end, n_end;

    logic              w_accept;
    logic [AW-1:0]     w_rd_addr;
    t_tbl_we           w_we;
    logic [AW-1:0]     w_wr_addr;
    logic [OWN_W-1:0]  w_wr_owner;
    logic [PW-1:0]     w_wr_next;
    logic [OWN_W-1:0]  w_q_owner;
    logic [PW-1:0]     w_q_next;
    logic [END_W-1:0]  w_q_end;
    logic [PW-1:0]     w_q_link;
    logic [PW-1:0]     w_len;
    logic              w_fits;
    logic              w_better;
    logic [LW-1:0]     w_split_ext;
    logic [PW-1:0]     w_split;
    logic [PW-1:0]     w_old_next;
    logic [LW-1:0]     w_pos_ext;

    fpma_seg_table #(
        .MEM_UNITS (MEM_UNITS),
        .AW        (AW),
        .PW        (PW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (w_rd_addr),
        .i_we       (w_we),
        .i_wr_addr  (w_wr_addr),
        .i_wr_owner (w_wr_owner),
        .i_wr_next  (w_wr_next),
        .i_wr_end   (r_end),
        .o_rd_owner (w_q_owner),
        .o_rd_next  (w_q_next),
        .o_rd_end   (w_q_end)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;

    assign w_q_link = f_link((r_state == S_MERGE) ? r_link : r_pos, w_q_next);
    assign w_len    = w_q_link - r_pos;
    assign w_fits   = (w_q_owner == FREE_MARK) && (LW'(w_len) >= LW'(r_size));
    assign w_better = !r_have ||
                      ((r_fit_mode == FIT_BEST) ? (w_len < r_best_len)
                                                : (w_len > r_best_len));

    assign w_split_ext = LW'(r_best) + LW'(r_size);
    assign w_split     = w_split_ext[PW-1:0];
    assign w_old_next  = r_best + r_best_len;
    assign w_pos_ext   = LW'(r_res_pos);

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_link       = r_link;
        n_best       = r_best;
        n_best_len   = r_best_len;
        n_have       = r_have;
        n_cur_free   = r_cur_free;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_owner      = r_owner;
        n_size       = r_size;
        n_now        = r_now;
        n_end        = r_end;
        n_out_valid  = r_out_valid && i_out_stall;
        n_status     = r_status;
        n_position   = r_position;
        w_rd_addr    = '0;
        w_we         = '0;
        w_wr_addr    = r_pos[AW-1:0];
        w_wr_owner   = FREE_MARK;
        w_wr_next    = r_link;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_owner   = OWN_W'(i_owner_id);
                    n_size    = i_req_size;
                    n_now     = i_now_time;
                    n_end     = END_W'(i_now_time) + END_W'(i_burst_time);
                    n_pos     = '0;
                    n_have    = 1'b0;
                    n_res_pos = '0;
                    if (i_req_type == REQ_RELEASE) begin
                        n_res_status = ST_RELEASE;
                        n_state      = S_REL;
                    end else if (i_req_size == '0) begin
                        n_res_status = ST_NOFIT;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (w_fits && r_fit_mode == FIT_FIRST) begin
                    n_best     = r_pos;
                    n_best_len = w_len;
                    n_state    = S_ALLOC;
                end else begin
                    if (w_fits && w_better) begin
                        n_best     = r_pos;
                        n_best_len = w_len;
                        n_have     = 1'b1;
                    end
                    if (w_q_link >= MEM_P) begin
                        if (n_have) begin
                            n_state = S_ALLOC;
                        end else begin
                            n_res_status = ST_NOFIT;
                            n_state      = S_DONE;
                        end
                    end else begin
                        n_pos     = w_q_link;
                        w_rd_addr = w_q_link[AW-1:0];
                    end
                end
            end
            S_ALLOC: begin
                w_we         = '{owner: 1'b1, next: 1'b1, end_time: 1'b1};
                w_wr_addr    = r_best[AW-1:0];
                w_wr_owner   = r_owner;
                w_wr_next    = w_split;
                n_res_status = ST_ALLOC;
                n_res_pos    = r_best;
                if (w_split != w_old_next && w_split < MEM_P) begin
                    n_pos   = w_split;
                    n_link  = w_old_next;
                    n_state = S_SPLIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SPLIT: begin
                w_we    = '{owner: 1'b1, next: 1'b1, end_time: 1'b0};
                n_state = S_DONE;
            end
            S_REL: begin
                if (w_q_end == END_W'(r_now)) begin
                    w_we.owner = 1'b1;
                end
                if (w_q_link >= MEM_P) begin
                    n_state = S_MISSUE;
                end else begin
                    n_pos     = w_q_link;
                    w_rd_addr = w_q_link[AW-1:0];
                end
            end
            S_MISSUE: begin
                n_pos   = '0;
                n_state = S_MSTART;
            end
            S_MSTART: begin
                n_cur_free = (w_q_owner == FREE_MARK);
                n_link     = w_q_link;
                if (w_q_link >= MEM_P) begin
                    n_state = S_DONE;
                end else begin
                    w_rd_addr = w_q_link[AW-1:0];
                    n_state   = S_MERGE;
                end
            end
            S_MERGE: begin
                n_link = w_q_link;
                if (r_cur_free && w_q_owner == FREE_MARK) begin
                    w_we.next = 1'b1;
                    w_wr_next = w_q_link;
                end else begin
                    n_pos      = r_link;
                    n_cur_free = (w_q_owner == FREE_MARK);
                end
                if (w_q_link >= MEM_P) begin
                    n_state = S_DONE;
                end else begin
                    w_rd_addr = w_q_link[AW-1:0];
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_position  = w_pos_ext[POS_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fit_mode  <= FIT_FIRST;
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
            r_cur_free  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_have      <= n_have;
            r_cur_free  <= n_cur_free;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fit_mode <= i_cfg_fit_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_link       <= n_link;
        r_best       <= n_best;
        r_best_len   <= n_best_len;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_owner      <= n_owner;
        r_size       <= n_size;
        r_now        <= n_now;
        r_end        <= n_end;
        r_status     <= n_status;
        r_position   <= n_position;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_position  = r_position;

endmodule
